@@ rtl/core/lkfe_pkg.sv @@
// lkfe_pkg: shared types, command bytes and glyph table for the led/key frame encoder
// depends on nothing; used by every module in rtl/core
package lkfe_pkg;

    localparam int NumDigits   = 8;
    localparam int NumKeyBytes = 4;
    localparam int NumBytes    = 19;
    localparam int IdxW        = $clog2(NumBytes);

    localparam logic [1:0] MODE_DISPLAY = 2'd0;
    localparam logic [1:0] MODE_OFF     = 2'd1;
    localparam logic [1:0] MODE_KEYSCAN = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [7:0] CMD_DISP_ON  = 8'h88;
    localparam logic [7:0] CMD_WRITE    = 8'h40;
    localparam logic [7:0] CMD_ADDR     = 8'hc0;
    localparam logic [7:0] CMD_DISP_OFF = 8'h80;
    localparam logic [7:0] CMD_READ_KEY = 8'h42;
    localparam logic [7:0] FILL_FIRST   = 8'h80;
    localparam logic [7:0] FILL_REST    = 8'h00;

    localparam logic [7:0] KEY_LO_A = 8'h04;
    localparam logic [7:0] KEY_LO_B = 8'h40;
    localparam logic [7:0] KEY_HI_A = 8'h02;
    localparam logic [7:0] KEY_HI_B = 8'h20;

    localparam logic [IdxW-1:0] IDX_WRITE = IdxW'(1);
    localparam logic [IdxW-1:0] IDX_ADDR  = IdxW'(2);
    localparam logic [IdxW-1:0] IDX_DATA0 = IdxW'(3);
    localparam logic [IdxW-1:0] IDX_LAST  = IdxW'(NumBytes - 1);

    localparam logic [2:0] BRIGHT_RESET = 3'd2;

    typedef struct packed {
        logic lo_a;
        logic lo_b;
        logic hi_a;
        logic hi_b;
    } key_hit_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
    } item_ctl_t;

    function automatic logic [7:0] glyph_of(input logic [4:0] code);
        logic [7:0] g;
        case (code)
            5'd0:    g = 8'h3f;
            5'd1:    g = 8'h06;
            5'd2:    g = 8'h5b;
            5'd3:    g = 8'h4f;
            5'd4:    g = 8'h66;
            5'd5:    g = 8'h6d;
            5'd6:    g = 8'h7d;
            5'd7:    g = 8'h07;
            5'd8:    g = 8'h7f;
            5'd9:    g = 8'h6f;
            5'd10:   g = 8'h77;
            5'd11:   g = 8'h7c;
            5'd12:   g = 8'h39;
            5'd13:   g = 8'h5e;
            5'd14:   g = 8'h79;
            5'd15:   g = 8'h71;
            5'd16:   g = 8'h40;
            5'd17:   g = 8'hef;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/core/lkfe_digit_lane.sv @@
// lkfe_digit_lane: one digit lane, seven-segment lookup into a holding register
// depends on lkfe_pkg (glyph table)
module lkfe_digit_lane (
    input  logic       aclk,
    input  logic       load,
    input  logic [4:0] code,
    output logic [7:0] glyph
);

    logic [7:0] glyph_reg;
    logic [7:0] glyph_next;

    assign glyph_next = lkfe_pkg::glyph_of(code);

    always_ff @(posedge aclk) begin
        if (load) begin
            glyph_reg <= glyph_next;
        end
    end

    assign glyph = glyph_reg;

endmodule

@@ rtl/core/lkfe_key_lane.sv @@
// lkfe_key_lane: one key-byte lane, exact matches against the four key patterns
// depends on lkfe_pkg (key patterns, key_hit_t)
module lkfe_key_lane (
    input  logic                aclk,
    input  logic                load,
    input  logic [7:0]          key_byte,
    output lkfe_pkg::key_hit_t  hit
);

    lkfe_pkg::key_hit_t hit_reg;
    lkfe_pkg::key_hit_t hit_next;

    always_comb begin
        hit_next.lo_a = (key_byte == lkfe_pkg::KEY_LO_A);
        hit_next.lo_b = (key_byte == lkfe_pkg::KEY_LO_B);
        hit_next.hi_a = (key_byte == lkfe_pkg::KEY_HI_A);
        hit_next.hi_b = (key_byte == lkfe_pkg::KEY_HI_B);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

@@ rtl/core/lkfe_frame_seq.sv @@
// lkfe_frame_seq: merges lane results (transpose, key priority) and sends one word a cycle while m_ready is high
// depends on lkfe_pkg; fed by lkfe_digit_lane and lkfe_key_lane
module lkfe_frame_seq (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [2:0]                                brightness,
    input  lkfe_pkg::item_ctl_t                       item,
    input  logic [lkfe_pkg::NumDigits-1:0][7:0]       glyphs,
    input  lkfe_pkg::key_hit_t [lkfe_pkg::NumKeyBytes-1:0] hits,
    output logic                                      take,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [7:0]                                m_out_byte,
    output logic                                      m_frame_start,
    output logic                                      m_last,
    output logic [4:0]                                m_key_number
);

    localparam int IdxW = lkfe_pkg::IdxW;

    logic                                 act_reg, act_next;
    logic [IdxW-1:0]                      idx_reg, idx_next;
    logic [lkfe_pkg::NumDigits-1:0][7:0]  data_reg, data_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [7:0]                           byte_reg, byte_next;
    logic                                 start_reg, start_next;
    logic                                 last_reg, last_next;
    logic [4:0]                           key_reg, key_next;
    logic [IdxW-1:0]                      rel_idx;
    logic [3:0]                           slot;
    logic                                 ld;

    function automatic logic [lkfe_pkg::NumDigits-1:0][7:0] transpose(
        input logic [lkfe_pkg::NumDigits-1:0][7:0] g
    );
        logic [lkfe_pkg::NumDigits-1:0][7:0] t;
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 8; j++) begin
                t[k][j] = g[7-j][k];
            end
        end
        return t;
    endfunction

    function automatic logic [4:0] key_decode(
        input lkfe_pkg::key_hit_t [lkfe_pkg::NumKeyBytes-1:0] h
    );
        logic [4:0] key;
        key = 5'd0;
        for (int i = lkfe_pkg::NumKeyBytes - 1; i >= 0; i--) begin
            if (h[i].hi_b) key = 5'(2 * i + 10);
            if (h[i].hi_a) key = 5'(2 * i + 9);
        end
        for (int i = lkfe_pkg::NumKeyBytes - 1; i >= 0; i--) begin
            if (h[i].lo_b) key = 5'(2 * i + 2);
            if (h[i].lo_a) key = 5'(2 * i + 1);
        end
        return key;
    endfunction

    assign ld      = !m_valid_reg || m_ready;
    assign rel_idx = idx_reg - lkfe_pkg::IDX_DATA0;
    assign slot    = rel_idx[3:0];

    always_comb begin
        act_next     = act_reg;
        idx_next     = idx_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        start_next   = start_reg;
        last_next    = last_reg;
        key_next     = key_reg;
        take         = 1'b0;
        if (ld) begin
            if (act_reg) begin
                m_valid_next = 1'b1;
                key_next     = 5'd0;
                idx_next     = idx_reg + IdxW'(1);
                act_next     = (idx_reg != lkfe_pkg::IDX_LAST);
                last_next    = (idx_reg == lkfe_pkg::IDX_LAST);
                case (idx_reg)
                    lkfe_pkg::IDX_WRITE: begin
                        byte_next  = lkfe_pkg::CMD_WRITE;
                        start_next = 1'b1;
                    end
                    lkfe_pkg::IDX_ADDR: begin
                        byte_next  = lkfe_pkg::CMD_ADDR;
                        start_next = 1'b1;
                    end
                    default: begin
                        start_next = 1'b0;
                        if (!slot[0]) begin
                            byte_next = data_reg[slot[3:1]];
                        end else if (slot[3:1] == 3'd0) begin
                            byte_next = lkfe_pkg::FILL_FIRST;
                        end else begin
                            byte_next = lkfe_pkg::FILL_REST;
                        end
                    end
                endcase
            end else if (item.valid) begin
                take         = 1'b1;
                m_valid_next = 1'b1;
                start_next   = 1'b1;
                key_next     = 5'd0;
                case (item.mode)
                    lkfe_pkg::MODE_DISPLAY: begin
                        byte_next = lkfe_pkg::CMD_DISP_ON | {5'd0, brightness};
                        last_next = 1'b0;
                        act_next  = 1'b1;
                        idx_next  = lkfe_pkg::IDX_WRITE;
                        data_next = transpose(glyphs);
                    end
                    lkfe_pkg::MODE_OFF: begin
                        byte_next = lkfe_pkg::CMD_DISP_OFF;
                        last_next = 1'b1;
                    end
                    default: begin
                        byte_next = lkfe_pkg::CMD_READ_KEY;
                        last_next = 1'b1;
                        key_next  = key_decode(hits);
                    end
                endcase
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            act_reg     <= act_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        byte_reg  <= byte_next;
        start_reg <= start_next;
        last_reg  <= last_next;
        key_reg   <= key_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_frame_start = start_reg;
    assign m_last        = last_reg;
    assign m_key_number  = key_reg;

    // a frame in progress always has a word on the output
    a_act_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        act_reg |-> m_valid_reg)
        else $error("frame in progress with empty output register");

    // the closing word of an item ends the frame
    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg) |-> !act_reg)
        else $error("last word shown while frame still active");

    // key numbers only travel with the key read command
    a_key_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && key_reg != 5'd0) |-> (byte_reg == lkfe_pkg::CMD_READ_KEY && last_reg))
        else $error("key number on a non key-read word");

    // no new item is pulled while a frame is still being sent
    a_no_take_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        act_reg |-> !take)
        else $error("item taken during an active frame");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (key_reg <= 5'd16))
        else $error("key number out of range");

endmodule

@@ rtl/core/led_key_frame_encoder_unit.sv @@
// led_key_frame_encoder_unit: top level of the led/key driver command frame encoder
// depends on lkfe_pkg, lkfe_digit_lane, lkfe_key_lane, lkfe_frame_seq
//
// input channel (s_valid/s_ready): one command word carries a mode, eight digit codes
// and four scanned key bytes. output channel (m_valid/m_ready): one byte per word,
// with frame_start, last and the decoded key number.
// config: cfg_wr_en writes cfg_wr_data into the brightness register.
// a display update gives 19 words, display off and key scan give one word each,
// mode 3 is accepted and gives none.
// an item is registered in the s1 and lane registers, then in the output register.
// the output register sends one word per cycle while m_ready is high; the next
// command is taken while the current frame is still being sent, one command is held
// ahead of the sender.
// eight digit lanes and four key lanes evaluate and register a command; the sender
// transposes the glyphs and picks the highest priority key.
// reset: brightness returns to 2 and the pipeline empties.
// when the receiver stalls, the output word holds and the input side fills, then
// s_ready drops until words are taken again.
module led_key_frame_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [4:0]  s_digit_0,
    input  logic [4:0]  s_digit_1,
    input  logic [4:0]  s_digit_2,
    input  logic [4:0]  s_digit_3,
    input  logic [4:0]  s_digit_4,
    input  logic [4:0]  s_digit_5,
    input  logic [4:0]  s_digit_6,
    input  logic [4:0]  s_digit_7,
    input  logic [31:0] s_key_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_start,
    output logic        m_last,
    output logic [4:0]  m_key_number
);

    logic [2:0]                                     bright_reg, bright_next;
    logic                                           s1_valid_reg, s1_valid_next;
    logic [1:0]                                     s1_mode_reg;
    logic                                           accept;
    logic                                           take;
    logic [lkfe_pkg::NumDigits-1:0][4:0]            codes;
    logic [lkfe_pkg::NumDigits-1:0][7:0]            glyphs;
    lkfe_pkg::key_hit_t [lkfe_pkg::NumKeyBytes-1:0] hits;
    lkfe_pkg::item_ctl_t                            item;

    assign codes = {s_digit_7, s_digit_6, s_digit_5, s_digit_4,
                    s_digit_3, s_digit_2, s_digit_1, s_digit_0};

    assign s_ready = !s1_valid_reg || take;
    assign accept  = s_valid && s_ready;

    assign bright_next = cfg_wr_en ? cfg_wr_data : bright_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = (s_mode != lkfe_pkg::MODE_NONE);
        end else if (take) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg   <= lkfe_pkg::BRIGHT_RESET;
            s1_valid_reg <= 1'b0;
        end else begin
            bright_reg   <= bright_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg <= s_mode;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < lkfe_pkg::NumDigits; gi++) begin : g_digit
            lkfe_digit_lane u_lane (
                .aclk  (aclk),
                .load  (accept),
                .code  (codes[gi]),
                .glyph (glyphs[gi])
            );
        end
        for (gi = 0; gi < lkfe_pkg::NumKeyBytes; gi++) begin : g_key
            lkfe_key_lane u_lane (
                .aclk     (aclk),
                .load     (accept),
                .key_byte (s_key_bytes[8*gi +: 8]),
                .hit      (hits[gi])
            );
        end
    endgenerate

    assign item.valid = s1_valid_reg;
    assign item.mode  = s1_mode_reg;

    lkfe_frame_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .brightness    (bright_reg),
        .item          (item),
        .glyphs        (glyphs),
        .hits          (hits),
        .take          (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_start (m_frame_start),
        .m_last        (m_last),
        .m_key_number  (m_key_number)
    );

endmodule
